[rtl/assert_macros.svh]
// assertion macros used by the port-level checker
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define VCRA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vcra assertion failed");

// clocked assertion that also holds during reset
`define VCRA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vcra assertion failed");

`endif

[rtl/vcra_pkg.sv]
// types, codes and widths for the vibrate command retry tracker
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package vcra_pkg;

  localparam int NUM_NODES = 3;
  localparam int IDX_W     = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;

  localparam int FUNC_W  = 2;
  localparam int NODE_W  = 2;
  localparam int MSG_W   = 32;
  localparam int TIME_W  = 32;
  localparam int RETRY_W = 4;
  localparam int IVL_W   = 16;
  localparam int KIND_W  = 2;

  localparam int IN_DATA_W  = 72;  // node, ack_msg_id, now_ms padded to bytes
  localparam int OUT_DATA_W = 40;  // target_node, msg_id, retry_count padded

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [IVL_W-1:0]   RESET_INTERVAL = IVL_W'(40);
  localparam logic [RETRY_W-1:0] RESET_MAX_RETRIES = RETRY_W'(6);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RETRY_INTERVAL = 1'b0,
    CFG_MAX_RETRIES    = 1'b1
  } cfg_reg_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_START   = 2'd0,
    FN_ACK     = 2'd1,
    FN_SERVICE = 2'd2
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND    = 2'd0,
    KIND_GAVE_UP = 2'd1,
    KIND_ACKED   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the input transaction
    logic scan;  // build the mask of nodes that give a result
    logic emit;  // process the lowest masked node into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mask_empty;  // no node left to process for this item
    logic out_free;    // output register can take a result this cycle
    logic emit_last;   // the selected node is the final one of this item
  } dp_status_t;

endpackage

[rtl/vibrate_command_retry_ack_top.sv]
// flow: the item is captured, the scan state builds the node mask, and the emit state writes
// one node per emit cycle to the output register; the next item waits until all are written
// the emit sequencer walks due nodes lowest first; a stalled output holds it
// reset (rst, synchronous, high): all entries closed, sequence number 0,
// retry interval 40 ms, max retries 6, no result pending
`timescale 1ns / 1ps

// top level: stop-and-wait retransmit tracker for vibrate commands
// depends on vcra_pkg, vcra_ctrl, vcra_dp

module vibrate_command_retry_ack_top import vcra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,

  // configuration writes, index 0 retry interval, index 1 max retries
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // node[1:0], ack_msg_id[33:2], now_ms[65:34]
  input  logic [FUNC_W-1:0]     s_axis_tuser,   // func[1:0]

  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // target_node[1:0], msg_id[33:2],
                                                // retry_count[37:34]
  output logic [KIND_W-1:0]     m_axis_tuser,   // kind[1:0]
  output logic                  m_axis_tlast    // last_result
);

  // command and status between the sequencer and the node table
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: takes one transaction at a time, then scans and emits
  vcra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // node table, sequence counter, config and the output register
  // the output register frees the input side while a result waits
  vcra_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_func   (s_axis_tuser),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[rtl/vcra_dp.sv]
// datapath: config registers, node table, sequence number, output register
// depends on vcra_pkg
`timescale 1ns / 1ps

module vcra_dp import vcra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [FUNC_W-1:0]     in_func,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [KIND_W-1:0]     out_kind,
  output logic                  out_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status
);

  logic [IVL_W-1:0]   retry_interval;
  logic [RETRY_W-1:0] max_retries;

  func_t             func_q;
  logic [NODE_W-1:0] node_q;
  logic [MSG_W-1:0]  ack_q;
  logic [TIME_W-1:0] now_q;

  logic [NUM_NODES-1:0] pend_valid;
  logic [MSG_W-1:0]     pend_msg     [NUM_NODES];
  logic [RETRY_W-1:0]   pend_retries [NUM_NODES];
  logic [TIME_W-1:0]    pend_sent    [NUM_NODES];
  logic [MSG_W-1:0]     seq_num;

  logic [NUM_NODES-1:0] mask;
  logic [NUM_NODES-1:0] mask_next;
  logic [NUM_NODES-1:0] sel_onehot;
  logic [IDX_W-1:0]     sel;

  logic                 node_ok;
  logic [MSG_W-1:0]     seq_inc;
  logic [MSG_W-1:0]     e_msg;
  logic [RETRY_W-1:0]   e_ret;
  logic                 wr_valid;
  logic                 wr_payload;
  logic                 seq_upd;
  kind_t                res_kind;
  logic [MSG_W-1:0]     res_msg;
  logic [RETRY_W-1:0]   res_ret;
  logic [NODE_W-1:0]    res_node;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval <= RESET_INTERVAL;
      max_retries    <= RESET_MAX_RETRIES;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RETRY_INTERVAL: retry_interval <= cfg_data[IVL_W-1:0];
        CFG_MAX_RETRIES:    max_retries    <= cfg_data[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func_t'(in_func);
      node_q <= in_data[NODE_W-1:0];
      ack_q  <= in_data[NODE_W +: MSG_W];
      now_q  <= in_data[NODE_W+MSG_W +: TIME_W];
    end
  end

  assign node_ok = (node_q != '0) && (32'(node_q) <= NUM_NODES);

  // one lane per node
  always_comb begin
    for (int i = 0; i < NUM_NODES; i++) begin
      case (func_q)
        FN_START:   mask_next[i] = node_ok && (32'(node_q) == i + 1);
        FN_ACK:     mask_next[i] = node_ok && (32'(node_q) == i + 1) && pend_valid[i] &&
                                   (pend_msg[i] == ack_q);
        FN_SERVICE: mask_next[i] = pend_valid[i] &&
                                   ((now_q - pend_sent[i]) >= TIME_W'(retry_interval));
        default:    mask_next[i] = 1'b0;
      endcase
    end
  end

  // lowest pending node first
  always_comb begin
    sel = '0;
    for (int i = NUM_NODES - 1; i >= 0; i--) begin
      if (mask[i]) sel = IDX_W'(i);
    end
  end

  always_comb begin
    sel_onehot      = '0;
    sel_onehot[sel] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cmd.scan) begin
      mask <= mask_next;
    end else if (cmd.emit) begin
      mask <= mask & ~sel_onehot;
    end
  end

  assign e_msg    = pend_msg[sel];
  assign e_ret    = pend_retries[sel];
  assign seq_inc  = seq_num + MSG_W'(1);
  assign res_node = NODE_W'(32'(sel) + 1);

  always_comb begin
    wr_valid   = 1'b0;
    wr_payload = 1'b0;
    seq_upd    = 1'b0;
    res_kind   = KIND_SEND;
    res_msg    = e_msg;
    res_ret    = e_ret;
    case (func_q)
      FN_START: begin
        wr_valid   = 1'b1;
        wr_payload = 1'b1;
        seq_upd    = 1'b1;
        res_msg    = seq_inc;
        res_ret    = '0;
      end
      FN_ACK: begin
        res_kind = KIND_ACKED;
      end
      FN_SERVICE: begin
        if (e_ret >= max_retries) begin
          res_kind = KIND_GAVE_UP;
        end else begin
          wr_valid   = 1'b1;
          wr_payload = 1'b1;
          res_ret    = e_ret + RETRY_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= '0;
      seq_num    <= '0;
    end else if (cmd.emit) begin
      pend_valid[sel] <= wr_valid;
      if (seq_upd) seq_num <= seq_inc;
    end
  end

  // a start writes the whole entry, so unwritten payload is never read
  always_ff @(posedge clk) begin
    if (cmd.emit && wr_payload) begin
      pend_msg[sel]     <= res_msg;
      pend_retries[sel] <= res_ret;
      pend_sent[sel]    <= now_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {{(OUT_DATA_W - NODE_W - MSG_W - RETRY_W){1'b0}}, res_ret, res_msg, res_node};
      out_kind <= res_kind;
      out_last <= status.emit_last;
    end
  end

  assign status.mask_empty = (mask == '0);
  assign status.out_free   = !out_valid || out_ready;
  assign status.emit_last  = ((mask & ~sel_onehot) == '0);

endmodule

[rtl/vcra_ctrl.sv]
// controller state machine: capture, scan, then one result per cycle while the output is free
// depends on vcra_pkg
`timescale 1ns / 1ps

module vcra_ctrl import vcra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output ctrl_cmd_t  cmd,
  input  dp_status_t status
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.mask_empty) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/vcra_checker.sv]
// port-level checker for the retry tracker, bound to the top level
// depends on vcra_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vcra_checker import vcra_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [KIND_W-1:0]     m_axis_tuser,
  input logic                  m_axis_tlast
);

  // a stalled result holds
  `VCRA_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // a result always names a real node
  `VCRA_ASSERT(a_node_nonzero, clk, rst, m_axis_tvalid |-> m_axis_tdata[NODE_W-1:0] != '0)

  // only the three result kinds appear
  `VCRA_ASSERT(a_kind_known, clk, rst, m_axis_tvalid |-> (m_axis_tuser == KIND_SEND || m_axis_tuser == KIND_GAVE_UP || m_axis_tuser == KIND_ACKED))

  // one item at a time: no transaction right after a transaction
  `VCRA_ASSERT(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // a fresh send with no retries is the last result of its item
  `VCRA_ASSERT(a_first_send, clk, rst, m_axis_tvalid && $rose(m_axis_tvalid) && m_axis_tuser == KIND_SEND && m_axis_tdata[NODE_W+MSG_W +: RETRY_W] == '0 |-> m_axis_tlast)

endmodule

bind vibrate_command_retry_ack_top vcra_checker u_vcra_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

// self-checking bench for vibrate_command_retry_ack_top: directed and random
// start, ack and service traffic scored against an in-bench retransmit tracker
// depends on vcra_pkg and the rtl of the block

module testbench;
  import vcra_pkg::*;

  // func code 3 has no meaning and must be dropped by the block
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam int QUIET_LIMIT   = 2000;  // cycles without any transaction
  localparam int ITEM_LATENCY  = 4;     // an item with no result may still be in flight
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 24;    // input items per random phase
  localparam int PAD_W         = IN_DATA_W - NODE_W - MSG_W - TIME_W;

  // one result transaction as the tracker predicts it
  typedef struct packed {
    kind_t               kind;
    logic [NODE_W-1:0]   node;
    logic [MSG_W-1:0]    msg;
    logic [RETRY_W-1:0]  retries;
    logic                last;
  } report_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // node, ack_msg_id, now_ms, zero pad
  logic [FUNC_W-1:0]     s_axis_tuser  = '0;  // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // target_node, msg_id, retry_count, zero pad
  logic [KIND_W-1:0]     m_axis_tuser;        // kind
  logic                  m_axis_tlast;        // last_result

  // tracker copy: open commands per node, sequence number and registers
  logic                  open_cmd     [1:NUM_NODES];
  logic [MSG_W-1:0]      open_msg     [1:NUM_NODES];
  logic [RETRY_W-1:0]    open_retries [1:NUM_NODES];
  logic [TIME_W-1:0]     open_sent    [1:NUM_NODES];
  logic [MSG_W-1:0]      seq_num;
  logic [IVL_W-1:0]      ivl_ms;
  logic [RETRY_W-1:0]    retry_cap;

  report_t               due_reports[$];  // results still owed by the block
  int                    fail_count   = 0;
  int                    quiet_cycles = 0;
  int                    rx_left      = 0;
  int                    item_count   = 0;  // accepted input items
  bit                    pace_on      = 1'b0;
  logic [TIME_W-1:0]     now_ms;            // millisecond time base of the stimulus

  vibrate_command_retry_ack_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly none, often short, now and then long
  function automatic int gap_len();
    int r;
    if (!pace_on) return 0;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // advance the tracker by one accepted item and queue the results it owes
  function automatic int advance_tracker(logic [FUNC_W-1:0] fn, logic [NODE_W-1:0] node,
                                         logic [MSG_W-1:0] ack, logic [TIME_W-1:0] now);
    int          n;
    bit          node_ok;
    logic [TIME_W-1:0] age;
    report_t     r;
    n = 0;
    node_ok = (node >= 1) && (node <= NUM_NODES);
    case (fn)
      FN_START: begin
        // a start to a busy node simply replaces the open command
        if (node_ok) begin
          seq_num            = seq_num + 1'b1;
          open_cmd[node]     = 1'b1;
          open_msg[node]     = seq_num;
          open_retries[node] = '0;
          open_sent[node]    = now;
          due_reports.push_back('{KIND_SEND, node, seq_num, RETRY_W'(0), 1'b0});
          n++;
        end
      end
      FN_ACK: begin
        // stale, foreign or mismatched acks fall through silently
        if (node_ok && open_cmd[node] && open_msg[node] == ack) begin
          open_cmd[node] = 1'b0;
          due_reports.push_back('{KIND_ACKED, node, open_msg[node], open_retries[node], 1'b0});
          n++;
        end
      end
      FN_SERVICE: begin
        for (int i = 1; i <= NUM_NODES; i++) begin
          age = now - open_sent[i];  // wraps at 32 bits
          if (open_cmd[i] && age >= TIME_W'(ivl_ms)) begin
            if (open_retries[i] >= retry_cap) begin
              open_cmd[i] = 1'b0;
              due_reports.push_back('{KIND_GAVE_UP, NODE_W'(i), open_msg[i],
                                      open_retries[i], 1'b0});
            end else begin
              open_retries[i] = open_retries[i] + 1'b1;
              open_sent[i]    = now;
              due_reports.push_back('{KIND_SEND, NODE_W'(i), open_msg[i],
                                      open_retries[i], 1'b0});
            end
            n++;
          end
        end
      end
      default: ;
    endcase
    if (n > 0) begin
      r = due_reports.pop_back();
      r.last = 1'b1;
      due_reports.push_back(r);
    end
    return n;
  endfunction

  // present one item, hold it until the transaction, then update the tracker;
  // valid stays high afterwards so back-to-back items need no extra edge
  task automatic send_item(logic [FUNC_W-1:0] fn, logic [NODE_W-1:0] node,
                           logic [MSG_W-1:0] ack, logic [TIME_W-1:0] now);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {{PAD_W{1'b0}}, now, ack, node};
    do @(posedge clk); while (!s_axis_tready);
    void'(advance_tracker(fn, node, ack, now));
    item_count++;
  endtask

  // stop sending and wait out every owed result plus any silent item in flight
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (ITEM_LATENCY) @(posedge clk);
  endtask

  // both registers in consecutive cycles; the block must be idle
  task automatic set_config(logic [IVL_W-1:0] ivl, logic [CFG_DATA_W-1:0] cap_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RETRY_INTERVAL;
    cfg_data  <= ivl;
    @(posedge clk);
    cfg_index <= CFG_MAX_RETRIES;
    cfg_data  <= cap_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ivl_ms    = ivl;
    retry_cap = cap_word[RETRY_W-1:0];
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // reset defaults: one full command life across the 32-bit time wrap,
  // then every kind of item the block has to drop
  task automatic test_ack_flow();
    logic [TIME_W-1:0] t0;
    logic [MSG_W-1:0]  id;
    pace_on = 1'b0;
    t0 = 32'hFFFF_FFE8;
    send_item(FN_START, 2'd1, $urandom, t0);
    id = open_msg[1];
    send_item(FN_SERVICE, 2'd0, '0, t0 + 39);   // one short of the interval
    send_item(FN_SERVICE, 2'd2, '1, t0 + 40);   // first retransmission, after the wrap
    send_item(FN_ACK, 2'd1, ~id, t0 + 41);      // wrong message id
    send_item(FN_ACK, 2'd1, id, t0 + 42);
    send_item(FN_ACK, 2'd1, id, t0 + 43);       // entry already closed
    send_item(FN_START, 2'd0, $urandom, t0 + 44);  // node out of range
    send_item(FN_ACK, 2'd0, id, t0 + 45);
    send_item(FN_UNUSED, 2'd3, '1, '1);
    send_item(FN_SERVICE, 2'd3, '0, t0 + 500);  // nothing open
    drain();
  endtask

  // register extremes: zero interval with zero retries, then the widest
  // interval with the largest retry limit
  task automatic test_config_extremes();
    logic [TIME_W-1:0] t0;
    t0 = $urandom;
    set_config('0, 16'hFFF0);  // bits above the retry field are dropped
    send_item(FN_START, 2'd1, '1, t0);
    send_item(FN_START, 2'd2, '0, t0);
    send_item(FN_START, 2'd3, '1, t0 + 5);
    send_item(FN_START, 2'd2, '1, t0 + 6);      // overwrite of a busy node
    send_item(FN_SERVICE, 2'd0, '0, t0 + 6);    // all three give up at once
    drain();
    set_config('1, 16'h000F);
    send_item(FN_START, 2'd2, $urandom, t0);
    send_item(FN_SERVICE, 2'd1, $urandom, t0 + 65534);
    send_item(FN_SERVICE, 2'd1, $urandom, t0 + 65535);
    drain();
  endtask

  // one command life with random content: start, some service passes
  // around the interval, and usually an ack with the right id
  task automatic exchange();
    logic [NODE_W-1:0] node;
    int                steps;
    int                iv;
    node  = NODE_W'($urandom_range(1, NUM_NODES));
    iv    = int'(ivl_ms);
    send_item(FN_START, node, $urandom, now_ms);
    steps = $urandom_range(0, retry_cap + 2);
    repeat (steps) begin
      now_ms = now_ms + $urandom_range(iv * 3 / 4, iv + 2);
      send_item(FN_SERVICE, NODE_W'($urandom), $urandom, now_ms);
    end
    if ($urandom_range(0, 2) != 0) send_item(FN_ACK, node, open_msg[node], now_ms);
  endtask

  // broken traffic: acks with a flipped id bit, or anything at all
  task automatic noise_item();
    logic [NODE_W-1:0] node;
    node = NODE_W'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0)
      send_item(FN_ACK, node, open_msg[(node == 0) ? 1 : node] ^ (32'd1 << $urandom_range(0, 31)),
                now_ms);
    else
      send_item(FUNC_W'($urandom_range(0, 3)), node, $urandom, $urandom);
  endtask

  // one register setting, mostly well-formed exchanges that overlap across
  // nodes; hold_mid pauses the sender until every result is back
  task automatic test_random_phase(logic [IVL_W-1:0] ivl, logic [RETRY_W-1:0] cap,
                                   bit paced, bit hold_mid);
    int  start_count;
    bit  held;
    set_config(ivl, {12'($urandom), cap});
    pace_on     = paced;
    now_ms      = $urandom;
    start_count = item_count;
    held        = 1'b0;
    while (item_count - start_count < PHASE_ITEMS) begin
      if ($urandom_range(0, 4) == 0) noise_item();
      else exchange();
      if (hold_mid && !held && item_count - start_count >= PHASE_ITEMS / 2) begin
        drain();
        held = 1'b1;
      end
    end
    drain();
  endtask

  // receiver: ready in runs, stalls of random length while pacing is on
  always @(posedge clk) begin : rx_pace
    int len;
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else begin
      len = gap_len();
      m_axis_tready <= (len == 0);
      rx_left       <= (len == 0) ? $urandom_range(0, 4) : len - 1;
    end
  end

  // score every result transaction against the oldest owed result
  always @(posedge clk) begin : result_check
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_reports.size() == 0) begin
        $error("unexpected result: kind %0d node %0d msg_id %0d",
               m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[33:2]);
        fail_count++;
      end else begin
        want = due_reports.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("target_node", 32'(want.node), 32'(m_axis_tdata[1:0]));
        check_field("msg_id", want.msg, m_axis_tdata[33:2]);
        check_field("retry_count", 32'(want.retries), 32'(m_axis_tdata[37:34]));
        check_field("last_result", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // watchdog: any transaction on either side restarts the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $error("no transaction for %0d cycles, %0d results still owed",
           QUIET_LIMIT, due_reports.size());
    $display("** vibrate_command_retry_ack_top: FAILED **");
    $finish;
  end

  initial begin
    for (int i = 1; i <= NUM_NODES; i++) begin
      open_cmd[i]     = 1'b0;
      open_msg[i]     = '0;
      open_retries[i] = '0;
      open_sent[i]    = '0;
    end
    seq_num   = '0;
    ivl_ms    = RESET_INTERVAL;
    retry_cap = RESET_MAX_RETRIES;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_ack_flow();
    test_config_extremes();
    test_random_phase(IVL_W'($urandom_range(20, 60)), RETRY_W'($urandom_range(1, 6)),
                      1'b1, 1'b0);
    test_random_phase('0, RETRY_W'($urandom_range(0, 3)), 1'b1, 1'b1);
    test_random_phase('1, 4'd15, 1'b0, 1'b0);  // long run with no idling
    test_random_phase(IVL_W'($urandom_range(0, 65535)), RETRY_W'($urandom_range(0, 15)),
                      1'b1, 1'b1);

    // late or extra results would show up here
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_reports.size() != 0) begin
      $error("%0d expected results never arrived", due_reports.size());
      fail_count++;
    end

    if (fail_count == 0)
      $display("** vibrate_command_retry_ack_top: PASSED **");
    else
      $display("** vibrate_command_retry_ack_top: FAILED **");
    $finish;
  end

endmodule
